[rtl/rdb_pkg.sv]
// ----------------------------------------------------------------------------
// rdb_pkg
// Shared constants, operation and status codes, and the command and status
// structs that join the controller and the datapath of the deque buffer.
// ----------------------------------------------------------------------------
package rdb_pkg;

   localparam int DEPTH    = 1024;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 11;

   localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP     = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic accept;
      logic load_now;
      logic load_pop;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dp_stat_type;

endpackage

[rtl/rdb_ram.sv]
// ----------------------------------------------------------------------------
// rdb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rdb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rdb_ctrl.sv]
// ----------------------------------------------------------------------------
// rdb_ctrl
// Controller for the deque buffer: input and result handshakes, and the wait
// state that covers the registered read of a pop.
// ----------------------------------------------------------------------------
module rdb_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rdb_pkg::MODE_W-1:0]   req_mode,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  rdb_pkg::dp_stat_type         stat,
   output rdb_pkg::dp_cmd_type          cmd
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;
   logic      pop_read;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == S_READ) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign pop_read  = accept && (req_mode == rdb_pkg::MODE_POP) && !stat.empty;

   assign cmd.accept   = accept;
   assign cmd.load_now = accept && !pop_read;
   assign cmd.load_pop = (state_ff == S_READ);
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_read) begin
               state_in     = S_READ;
               rsp_valid_in = 1'b0;
            end else if (accept) begin
               rsp_valid_in = 1'b1;
            end else if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_in = 1'b0;
            end
         end
         S_READ: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/rdb_datapath.sv]
// ----------------------------------------------------------------------------
// rdb_datapath
// Ring pointers, entry count, reversal flag, entry RAM and result register
// of the deque buffer.
// ----------------------------------------------------------------------------
module rdb_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rdb_pkg::dp_cmd_type                 cmd,
   input  logic [rdb_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [rdb_pkg::DATA_W-1:0]   req_value,
   output rdb_pkg::dp_stat_type                stat,
   output logic signed [rdb_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic [rdb_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rdb_pkg::OCC_W-1:0]           rsp_occupancy,
   output logic                                rsp_reversed
);

   logic [rdb_pkg::IDX_W-1:0]    head_ff, head_in;
   logic [rdb_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         flag_ff, flag_in;
   logic [rdb_pkg::SUM_W-1:0]    back_sum;
   logic [rdb_pkg::IDX_W-1:0]    back_addr;
   logic [rdb_pkg::IDX_W-1:0]    last_addr;
   logic [rdb_pkg::IDX_W-1:0]    head_inc;
   logic [rdb_pkg::IDX_W-1:0]    head_dec;
   logic [rdb_pkg::STATUS_W-1:0] code;
   logic                         wr_en;
   logic [rdb_pkg::IDX_W-1:0]    wr_addr;
   logic                         rd_en;
   logic [rdb_pkg::IDX_W-1:0]    rd_addr;
   logic [rdb_pkg::DATA_W-1:0]   rd_data;

   logic signed [rdb_pkg::DATA_W-1:0] popped_ff;
   logic [rdb_pkg::STATUS_W-1:0]      status_ff;
   logic [rdb_pkg::OCC_W-1:0]         occ_ff;
   logic                              rev_ff;

   function automatic logic [rdb_pkg::IDX_W-1:0] wrap(input logic [rdb_pkg::SUM_W-1:0] s);
      logic [rdb_pkg::SUM_W-1:0] r;
      r = s;
      if (s >= rdb_pkg::SUM_W'(rdb_pkg::DEPTH)) begin
         r = s - rdb_pkg::SUM_W'(rdb_pkg::DEPTH);
      end
      return r[rdb_pkg::IDX_W-1:0];
   endfunction

   assign stat.full  = (count_ff == rdb_pkg::CNT_W'(rdb_pkg::DEPTH));
   assign stat.empty = (count_ff == '0);

   assign back_sum  = rdb_pkg::SUM_W'(head_ff) + rdb_pkg::SUM_W'(count_ff);
   assign back_addr = wrap(back_sum);
   assign last_addr = wrap(back_sum - rdb_pkg::SUM_W'(1));
   assign head_inc  = (head_ff == rdb_pkg::IDX_W'(rdb_pkg::DEPTH - 1)) ? '0
                                                                       : head_ff + 1'b1;
   assign head_dec  = (head_ff == '0) ? rdb_pkg::IDX_W'(rdb_pkg::DEPTH - 1)
                                      : head_ff - 1'b1;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      flag_in  = flag_ff;
      code     = rdb_pkg::ST_DONE;
      wr_en    = 1'b0;
      wr_addr  = flag_ff ? head_dec : back_addr;
      rd_en    = 1'b0;
      rd_addr  = flag_ff ? last_addr : head_ff;
      if (cmd.accept) begin
         case (req_mode)
            rdb_pkg::MODE_PUSH: begin
               if (stat.full) begin
                  code = rdb_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (flag_ff) begin
                     head_in = head_dec;
                  end
               end
            end
            rdb_pkg::MODE_REVERSE: begin
               flag_in = !flag_ff;
            end
            rdb_pkg::MODE_POP: begin
               if (stat.empty) begin
                  code = rdb_pkg::ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  count_in = count_ff - 1'b1;
                  if (!flag_ff) begin
                     head_in = head_inc;
                  end
               end
            end
            default: begin
               code = rdb_pkg::ST_DONE;
            end
         endcase
      end
   end

   rdb_ram #(
      .WIDTH (rdb_pkg::DATA_W),
      .DEPTH (rdb_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_now) begin
         popped_ff <= '0;
         status_ff <= code;
         occ_ff    <= rdb_pkg::OCC_W'(count_in);
         rev_ff    <= flag_in;
      end else if (cmd.load_pop) begin
         popped_ff <= signed'(rd_data);
         status_ff <= rdb_pkg::ST_DONE;
         occ_ff    <= rdb_pkg::OCC_W'(count_ff);
         rev_ff    <= flag_ff;
      end
   end

   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = occ_ff;
   assign rsp_reversed     = rev_ff;

endmodule

[rtl/reversible_deque_buffer.sv]
// ----------------------------------------------------------------------------
// reversible_deque_buffer
// Double-ended buffer over a ring of entries with a lazy reversal flag.
//
// Each request beat carries one operation: push req_value at the logical
// back, toggle the reversal flag, or pop the logical front. Every request
// beat yields exactly one response beat with the popped word (zero unless a
// pop succeeds), a status code, the occupancy and the reversal flag after
// the operation. A push into a full ring and a pop from an empty ring leave
// the state unchanged and report their status.
// Push, reverse, refused pop and the unused code: response in the cycle
// after the request beat, one beat per cycle sustained while rsp_stall is
// low. A successful pop: the word passes the registered read port of the
// entry RAM and then the response register; no request is taken in S_READ.
// Reset clears the pointers, count, flag and response valid; the entry RAM
// is not cleared and needs no clearing pass. While rsp_stall holds a
// response, req_stall is raised and no new request is taken.
// ----------------------------------------------------------------------------
module reversible_deque_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rdb_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [rdb_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rdb_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic [rdb_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rdb_pkg::OCC_W-1:0]           rsp_occupancy,
   output logic                                rsp_reversed
);

   rdb_pkg::dp_cmd_type  cmd;
   rdb_pkg::dp_stat_type stat;

   rdb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rdb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .stat             (stat),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_reversed     (rsp_reversed)
   );

endmodule

[rtl/rdb_checker.sv]
// ----------------------------------------------------------------------------
// rdb_checker
// Port-level checks for the deque buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rdb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [rdb_pkg::DATA_W-1:0]   rsp_popped_value,
   input logic [rdb_pkg::STATUS_W-1:0]        rsp_status,
   input logic [rdb_pkg::OCC_W-1:0]           rsp_occupancy,
   input logic                                rsp_reversed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_popped_value) && $stable(rsp_status)
                                 && $stable(rsp_occupancy) && $stable(rsp_reversed))
      else $error("response beat changed while stalled");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rdb_pkg::ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("refused pop reports nonzero occupancy");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rdb_pkg::ST_DONE) |-> (rsp_popped_value == '0))
      else $error("refused operation reports a popped word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind reversible_deque_buffer rdb_checker u_rdb_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the reversible deque buffer. A behavioral model
// of the ring, the head pointer, the count and the reversal flag predicts the
// response to every request beat. A separate process compares each response
// beat, field by field, with the oldest prediction. The run covers directed
// corner cases, a fill to full with operations at the full mark, random
// operation mixes, a sender pause and a long receiver hold-off. Both sides
// idle at random, except in the fill and on the sender side in the hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rdb_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic signed [rdb_pkg::DATA_W-1:0] popped;
      logic [rdb_pkg::STATUS_W-1:0]      status;
      logic [rdb_pkg::OCC_W-1:0]         occupancy;
      logic                              reversed;
   } deque_reply_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [rdb_pkg::MODE_W-1:0]        req_mode = rdb_pkg::MODE_PUSH;
   logic signed [rdb_pkg::DATA_W-1:0] req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [rdb_pkg::DATA_W-1:0] rsp_popped_value;
   logic [rdb_pkg::STATUS_W-1:0]      rsp_status;
   logic [rdb_pkg::OCC_W-1:0]         rsp_occupancy;
   logic                              rsp_reversed;

   logic [rdb_pkg::DATA_W-1:0] ring_words [rdb_pkg::DEPTH];
   int                         ring_head = 0;
   int                         ring_count = 0;
   bit                         ring_reversed = 1'b0;

   deque_reply_type pending_results [$];
   int              error_count = 0;
   bit              in_idle_on = 1'b1;
   bit              out_idle_on = 1'b1;
   int              hold_request = 0;

   reversible_deque_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_reversed     (rsp_reversed)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAIL reversible_deque_buffer");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic deque_reply_type apply_deque_op(
      input logic [rdb_pkg::MODE_W-1:0]        mode,
      input logic signed [rdb_pkg::DATA_W-1:0] value);
      deque_reply_type r;
      r.popped = '0;
      r.status = rdb_pkg::ST_DONE;
      case (mode)
         rdb_pkg::MODE_PUSH: begin
            if (ring_count >= rdb_pkg::DEPTH) begin
               r.status = rdb_pkg::ST_FULL;
            end else if (!ring_reversed) begin
               ring_words[(ring_head + ring_count) % rdb_pkg::DEPTH] = value;
               ring_count++;
            end else begin
               ring_head = (ring_head + rdb_pkg::DEPTH - 1) % rdb_pkg::DEPTH;
               ring_words[ring_head] = value;
               ring_count++;
            end
         end
         rdb_pkg::MODE_REVERSE: begin
            ring_reversed = !ring_reversed;
         end
         rdb_pkg::MODE_POP: begin
            if (ring_count == 0) begin
               r.status = rdb_pkg::ST_EMPTY;
            end else if (!ring_reversed) begin
               r.popped = ring_words[ring_head];
               ring_head = (ring_head + 1) % rdb_pkg::DEPTH;
               ring_count--;
            end else begin
               r.popped = ring_words[(ring_head + ring_count - 1) % rdb_pkg::DEPTH];
               ring_count--;
            end
         end
         default: begin
         end
      endcase
      r.occupancy = rdb_pkg::OCC_W'(ring_count);
      r.reversed  = ring_reversed;
      return r;
   endfunction

   function automatic logic signed [rdb_pkg::DATA_W-1:0] draw_word();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the beat is taken.
   task automatic send_op(input logic [rdb_pkg::MODE_W-1:0] mode,
                          input logic signed [rdb_pkg::DATA_W-1:0] value);
      int gap;
      gap = in_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), apply_deque_op(mode, value));
   endtask

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            stall_left = out_idle_on ? $urandom_range(0, 4) : 0;
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : response_check
      deque_reply_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response beat with no prediction waiting");
            end else begin
               want = pending_results[0];
               pending_results.delete(0);
               if (rsp_popped_value !== want.popped)
                  report_mismatch($sformatf("popped_value %0d, predicted %0d",
                                            rsp_popped_value, want.popped));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_status, want.status));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                            rsp_occupancy, want.occupancy));
               if (rsp_reversed !== want.reversed)
                  report_mismatch($sformatf("reversed %0b, predicted %0b",
                                            rsp_reversed, want.reversed));
            end
         end
      end
   end

   task automatic test_directed();
      in_idle_on  = 1'b1;
      out_idle_on = 1'b1;
      send_op(rdb_pkg::MODE_POP, 32'sh7FFF_FFFF);
      send_op(rdb_pkg::MODE_REVERSE, '0);
      send_op(rdb_pkg::MODE_POP, '1);
      send_op(MODE_UNUSED, 32'sh7FFF_FFFF);
      send_op(rdb_pkg::MODE_REVERSE, '1);
      send_op(rdb_pkg::MODE_PUSH, 32'sh8000_0000);
      send_op(rdb_pkg::MODE_PUSH, 32'sh7FFF_FFFF);
      send_op(rdb_pkg::MODE_PUSH, '0);
      send_op(rdb_pkg::MODE_PUSH, '1);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(rdb_pkg::MODE_REVERSE, '0);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(rdb_pkg::MODE_PUSH, 32'sh1234_5678);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(MODE_UNUSED, '1);
      send_op(rdb_pkg::MODE_REVERSE, '0);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(rdb_pkg::MODE_REVERSE, '0);
      send_op(rdb_pkg::MODE_PUSH, 32'sh5555_5555);
      send_op(rdb_pkg::MODE_PUSH, 32'shAAAA_AAAA);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(rdb_pkg::MODE_POP, '0);
      send_op(rdb_pkg::MODE_REVERSE, '0);
   endtask

   task automatic test_fill();
      in_idle_on  = 1'b0;
      out_idle_on = 1'b0;
      while (ring_count < rdb_pkg::DEPTH) begin
         if ($urandom_range(0, 63) == 0) send_op(rdb_pkg::MODE_REVERSE, $urandom());
         else send_op(rdb_pkg::MODE_PUSH, draw_word());
      end
      in_idle_on  = 1'b1;
      out_idle_on = 1'b1;
      send_op(rdb_pkg::MODE_PUSH, draw_word());
      send_op(rdb_pkg::MODE_REVERSE, $urandom());
      send_op(rdb_pkg::MODE_PUSH, draw_word());
      send_op(MODE_UNUSED, $urandom());
      send_op(rdb_pkg::MODE_POP, $urandom());
      send_op(rdb_pkg::MODE_PUSH, draw_word());
      send_op(rdb_pkg::MODE_PUSH, draw_word());
   endtask

   task automatic test_random_mix(input int n_items);
      int pick;
      int push_pct;
      int left;
      left = n_items;
      while (left > 0) begin
         push_pct    = $urandom_range(25, 75);
         in_idle_on  = ($urandom_range(0, 3) != 0);
         out_idle_on = ($urandom_range(0, 3) != 0);
         repeat (50) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               send_op(MODE_UNUSED, $urandom());
            end else if (pick < 14) begin
               send_op(rdb_pkg::MODE_REVERSE, $urandom());
            end else if (pick < 14 + push_pct * 86 / 100) begin
               send_op(rdb_pkg::MODE_PUSH, draw_word());
            end else begin
               send_op(rdb_pkg::MODE_POP, $urandom());
            end
         end
         left -= 50;
      end
      in_idle_on  = 1'b1;
      out_idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() > 0);
      @(posedge clock);
   endtask

   task automatic test_backpressure();
      test_sender_pause();
      @(negedge clock);
      hold_request = 300;
      @(posedge clock);
      in_idle_on = 1'b0;
      repeat (40) begin
         if ($urandom_range(0, 2) == 0) send_op(rdb_pkg::MODE_POP, $urandom());
         else send_op(rdb_pkg::MODE_PUSH, draw_word());
      end
      in_idle_on = 1'b1;
   endtask

   initial begin : run
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill();
      test_random_mix(50);
      test_sender_pause();
      test_backpressure();
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() > 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_results.size() > 0)
         report_mismatch($sformatf("%0d predicted responses never arrived",
                                   pending_results.size()));
      if (error_count == 0) begin
         $display("PASS reversible_deque_buffer");
      end else begin
         $display("FAIL reversible_deque_buffer");
      end
      $finish;
   end

endmodule
